// File: src/rana_pkg.sv
// Shared types and codes for the rational arithmetic normalize block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rana_pkg;

    // Operation codes on the input channel
    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    // Result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STS_DIV_ZERO = 2'd2;
    localparam logic [1:0] STS_OVERFLOW = 2'd3;

    // Datapath operations issued by the controller
    typedef logic [3:0] t_dp_op;
    localparam t_dp_op DP_NOP   = 4'd0;
    localparam t_dp_op DP_LOAD  = 4'd1;
    localparam t_dp_op DP_MUL0  = 4'd2;
    localparam t_dp_op DP_MUL1  = 4'd3;
    localparam t_dp_op DP_MUL2  = 4'd4;
    localparam t_dp_op DP_ADD   = 4'd5;
    localparam t_dp_op DP_GCD2  = 4'd6;
    localparam t_dp_op DP_GCDU  = 4'd7;
    localparam t_dp_op DP_GCDR  = 4'd8;
    localparam t_dp_op DP_DIVI  = 4'd9;
    localparam t_dp_op DP_DIV   = 4'd10;
    localparam t_dp_op DP_OUT   = 4'd11;

    // Datapath status seen by the controller
    typedef struct packed {
        logic err;        // early error captured at load
        logic zero_num;   // numerator sum is zero
        logic both_even;  // GCD: common factor of two remains
        logic u_even;     // GCD: u still even
        logic v_zero;     // GCD: reduction finished
        logic div_last;   // last division step
    } t_dp_sts;

endpackage
`default_nettype wire

// File: src/rational_arith_normalize_core.sv
// Rational arithmetic unit with normalization and GCD reduction.
// Input channel: i_valid / o_stall carries i_cmd and four signed operand fields
// (numerators and denominators of a and b). A transaction is taken when
// i_valid is high and o_stall is low; o_stall is high while one is in work.
// Output channel: o_valid / i_stall carries o_res_num, o_res_den, o_status.
// The result sits in an output register; the next input transaction can be
// taken while it waits, and the finished result of that one is held until
// the register is free. A stalled result does not change.
// Sequence from the accepting edge to the result load: a zero denominator or
// divide by zero goes straight to the output step; a zero numerator passes the
// three multiply steps and the add first; otherwise the three multiply steps,
// one add, the binary GCD shifts and subtracts, the restoring division steps
// for both quotients and the output step follow in that order. The next
// transaction is taken in the cycle after the load. One transaction is in
// work at a time.
// Reset (i_rst_n low, synchronous) empties the output register and returns
// the sequencer to idle; no clearing pass is needed.
// Depends on rana_pkg, rana_ctrl and rana_dp.
`timescale 1ns / 1ps
`default_nettype none
module rational_arith_normalize_core
    import rana_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_cmd,
    input  wire  [31:0] i_a_num,
    input  wire  [31:0] i_a_den,
    input  wire  [31:0] i_b_num,
    input  wire  [31:0] i_b_den,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_res_num,
    output logic [30:0] o_res_den,
    output logic [1:0]  o_status
);

    t_dp_op  op;
    t_dp_sts sts;

    // Sequencer
    rana_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_op    (op)
    );

    // Arithmetic and result register
    rana_dp #(
        .W (OPERAND_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_op      (op),
        .i_cmd     (i_cmd),
        .i_a_num   (i_a_num),
        .i_a_den   (i_a_den),
        .i_b_num   (i_b_num),
        .i_b_den   (i_b_den),
        .o_sts     (sts),
        .o_res_num (o_res_num),
        .o_res_den (o_res_den),
        .o_status  (o_status)
    );

endmodule
`default_nettype wire

// File: src/rana_ctrl.sv
// Sequencer for the rational arithmetic normalize block.
// Depends on rana_pkg; drives datapath operations and both handshakes.
`timescale 1ns / 1ps
`default_nettype none
module rana_ctrl
    import rana_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  wire     i_stall,
    input  t_dp_sts i_sts,
    output t_dp_op  o_op
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_ADD  = 4'd4;
    localparam logic [3:0] S_GCD2 = 4'd5;
    localparam logic [3:0] S_GCDU = 4'd6;
    localparam logic [3:0] S_GCDR = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_valid, n_valid;

    // Sequence the operations of one transaction
    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_MUL0;
                end
            end
            S_MUL0: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = DP_MUL0;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_op    = DP_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_op    = DP_MUL2;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_op    = DP_ADD;
                n_state = S_GCD2;
            end
            S_GCD2: begin
                if (i_sts.zero_num) begin
                    n_state = S_DONE;
                end else if (i_sts.both_even) begin
                    o_op = DP_GCD2;
                end else begin
                    n_state = S_GCDU;
                end
            end
            S_GCDU: begin
                if (i_sts.u_even) begin
                    o_op = DP_GCDU;
                end else begin
                    n_state = S_GCDR;
                end
            end
            S_GCDR: begin
                if (i_sts.v_zero) begin
                    o_op    = DP_DIVI;
                    n_state = S_DIV;
                end else begin
                    o_op = DP_GCDR;
                end
            end
            S_DIV: begin
                o_op = DP_DIV;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_valid || !i_stall) begin
                    o_op    = DP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result valid until the receiver takes it
    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (o_op == DP_OUT) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// File: src/rana_dp.sv
// Datapath: operand capture, shared multiplier, signed add, binary GCD,
// dual restoring divider and output register. Depends on rana_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rana_dp
    import rana_pkg::*;
#(
    parameter int W = 32
) (
    input  wire          i_clk,
    input  t_dp_op       i_op,
    input  wire  [1:0]   i_cmd,
    input  wire  [31:0]  i_a_num,
    input  wire  [31:0]  i_a_den,
    input  wire  [31:0]  i_b_num,
    input  wire  [31:0]  i_b_den,
    output t_dp_sts      o_sts,
    output logic [31:0]  o_res_num,
    output logic [30:0]  o_res_den,
    output logic [1:0]   o_status
);

    localparam int W2 = 2 * W;
    localparam int CW = $clog2(W2 + 1);
    localparam logic [W2-1:0] HALF = {{(W2-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic          r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [1:0]    r_cmd;
    logic [1:0]    r_stat;
    logic [W2-1:0] r_n1, r_n2, r_n, r_d, r_u, r_v, r_g;
    logic          r_s1, r_s2, r_sd, r_neg, r_zero;
    logic [CW-1:0] r_sh, r_cnt;
    logic [W2:0]   r_rn, r_rd;
    logic [31:0]   r_res_num;
    logic [30:0]   r_res_den;
    logic [1:0]    r_status;

    logic [W-1:0]  an_v, ad_v, bn_v, bd_v;
    logic [W-1:0]  mul_a, mul_b;
    logic [W2-1:0] prod;
    logic [W2-1:0] sum_mag;
    logic          sum_neg;
    logic [W2:0]   rn_sh, rd_sh;
    logic [W2:0]   rn_sub, rd_sub;
    logic          ovf;
    logic [31:0]   nm32;

    // Take the low operand bits of each field
    assign an_v = i_a_num[W-1:0];
    assign ad_v = i_a_den[W-1:0];
    assign bn_v = i_b_num[W-1:0];
    assign bd_v = i_b_den[W-1:0];

    // Select multiplier operands per step
    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (i_op)
            DP_MUL0: begin
                mul_a = r_an;
                mul_b = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            DP_MUL1: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            DP_MUL2: begin
                mul_a = r_ad;
                mul_b = (r_cmd == CMD_DIV) ? r_bn : r_bd;
            end
            default: ;
        endcase
    end

    assign prod = W2'(mul_a) * W2'(mul_b);

    // Sign-magnitude sum of the two numerator products
    always_comb begin
        if (r_s1 == r_s2) begin
            sum_mag = r_n1 + r_n2;
            sum_neg = r_s1;
        end else if (r_n1 >= r_n2) begin
            sum_mag = r_n1 - r_n2;
            sum_neg = r_s1;
        end else begin
            sum_mag = r_n2 - r_n1;
            sum_neg = r_s2;
        end
    end

    // Restoring division step for both quotients
    assign rn_sh  = {r_rn[W2-1:0], r_n[W2-1]};
    assign rd_sh  = {r_rd[W2-1:0], r_d[W2-1]};
    assign rn_sub = rn_sh - {1'b0, r_g};
    assign rd_sub = rd_sh - {1'b0, r_g};

    // Range check on the reduced fraction
    assign ovf = (r_d > HALF - 1'b1) || (r_neg ? (r_n > HALF) : (r_n > HALF - 1'b1));
    assign nm32 = 32'(r_n[W-1:0]);

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_cmd  <= i_cmd;
                r_an_s <= an_v[W-1];
                r_ad_s <= ad_v[W-1];
                r_bn_s <= bn_v[W-1];
                r_bd_s <= bd_v[W-1];
                r_an   <= an_v[W-1] ? (~an_v + 1'b1) : an_v;
                r_ad   <= ad_v[W-1] ? (~ad_v + 1'b1) : ad_v;
                r_bn   <= bn_v[W-1] ? (~bn_v + 1'b1) : bn_v;
                r_bd   <= bd_v[W-1] ? (~bd_v + 1'b1) : bd_v;
                if (ad_v == '0 || bd_v == '0) begin
                    r_stat <= STS_ZERO_DEN;
                end else if (i_cmd == CMD_DIV && bn_v == '0) begin
                    r_stat <= STS_DIV_ZERO;
                end else begin
                    r_stat <= STS_OK;
                end
                r_zero <= 1'b0;
            end
            DP_MUL0: begin
                r_n1 <= prod;
                r_s1 <= r_an_s ^ ((r_cmd == CMD_MUL) ? r_bn_s : r_bd_s);
            end
            DP_MUL1: begin
                r_n2 <= (r_cmd == CMD_MUL || r_cmd == CMD_DIV) ? '0 : prod;
                r_s2 <= r_bn_s ^ r_ad_s ^ (r_cmd == CMD_SUB);
            end
            DP_MUL2: begin
                r_d  <= prod;
                r_sd <= r_ad_s ^ ((r_cmd == CMD_DIV) ? r_bn_s : r_bd_s);
            end
            DP_ADD: begin
                r_n    <= sum_mag;
                r_u    <= sum_mag;
                r_v    <= r_d;
                r_neg  <= sum_neg ^ r_sd;
                r_zero <= (sum_mag == '0);
                r_sh   <= '0;
            end
            DP_GCD2: begin
                r_u  <= r_u >> 1;
                r_v  <= r_v >> 1;
                r_sh <= r_sh + 1'b1;
            end
            DP_GCDU: begin
                r_u <= r_u >> 1;
            end
            DP_GCDR: begin
                if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= r_v;
                    r_v <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            DP_DIVI: begin
                r_g   <= r_u << r_sh;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cnt <= '0;
            end
            DP_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                if (!rn_sub[W2]) begin
                    r_rn <= rn_sub;
                    r_n  <= {r_n[W2-2:0], 1'b1};
                end else begin
                    r_rn <= rn_sh;
                    r_n  <= {r_n[W2-2:0], 1'b0};
                end
                if (!rd_sub[W2]) begin
                    r_rd <= rd_sub;
                    r_d  <= {r_d[W2-2:0], 1'b1};
                end else begin
                    r_rd <= rd_sh;
                    r_d  <= {r_d[W2-2:0], 1'b0};
                end
            end
            DP_OUT: begin
                if (r_stat != STS_OK) begin
                    r_res_num <= '0;
                    r_res_den <= 31'd1;
                    r_status  <= r_stat;
                end else if (r_zero) begin
                    r_res_num <= '0;
                    r_res_den <= 31'd1;
                    r_status  <= STS_OK;
                end else if (ovf) begin
                    r_res_num <= '0;
                    r_res_den <= 31'd1;
                    r_status  <= STS_OVERFLOW;
                end else begin
                    r_res_num <= r_neg ? (32'd0 - nm32) : nm32;
                    r_res_den <= 31'(r_d[W-1:0]);
                    r_status  <= STS_OK;
                end
            end
            default: ;
        endcase
    end

    // Report progress to the controller
    assign o_sts.err       = (r_stat != STS_OK);
    assign o_sts.zero_num  = r_zero;
    assign o_sts.both_even = !r_u[0] && !r_v[0];
    assign o_sts.u_even    = !r_u[0];
    assign o_sts.v_zero    = (r_v == '0);
    assign o_sts.div_last  = (r_cnt == CW'(W2 - 1));

    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

endmodule
`default_nettype wire

// File: bench/tb_rational_arith_normalize_core.sv
// Self-checking bench for rational_arith_normalize_core: directed and random fractions,
// predicted in sign-magnitude at double width and reduced by GCD, compared per field.
// Depends on rana_pkg and the RTL of the core.
`timescale 1ns / 1ps
module tb_rational_arith_normalize_core;
    import rana_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] a_num, a_den, b_num, b_den;
    } t_op_item;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
    } t_fraction;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = '0;
    logic [31:0] i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_res_num;
    logic [30:0] o_res_den;
    logic [1:0]  o_status;

    t_op_item  pending_ops[$];
    t_fraction expected_fractions[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        stimulus_done = 1'b0;
    int        send_wait = 0;
    int        recv_wait = 0;

    rational_arith_normalize_core #(.OPERAND_WIDTH(32)) DUT (.*);

    always #10 i_clk = ~i_clk;

    // Exact binary GCD on magnitudes; both nonzero
    function automatic logic [63:0] gcd_mag(logic [63:0] u, logic [63:0] v);
        int          shift;
        logic [63:0] t;
        shift = 0;
        while (((u | v) & 64'd1) == 0) begin
            u = u >> 1;
            v = v >> 1;
            shift++;
        end
        while (u[0] == 1'b0) u = u >> 1;
        while (v != 0) begin
            while (v[0] == 1'b0) v = v >> 1;
            if (u > v) begin
                t = u; u = v; v = t;
            end
            v = v - u;
        end
        return u << shift;
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // Work out the normalized fraction for one operation
    function automatic t_fraction reduce_fraction(t_op_item it);
        t_fraction   r;
        logic [63:0] p1, p2, nm, dm, g;
        logic        s1, s2, nneg, dneg, neg;
        r = '{num: 32'd0, den: 31'd1, status: STS_OK};
        if (it.a_den == 0 || it.b_den == 0) begin
            r.status = STS_ZERO_DEN;
            return r;
        end
        if (it.cmd == CMD_DIV && it.b_num == 0) begin
            r.status = STS_DIV_ZERO;
            return r;
        end
        case (it.cmd)
            CMD_ADD, CMD_SUB: begin
                p1 = mag32(it.a_num) * mag32(it.b_den);
                s1 = (it.a_num[31] ^ it.b_den[31]) && p1 != 0;
                p2 = mag32(it.b_num) * mag32(it.a_den);
                s2 = (it.b_num[31] ^ it.a_den[31]) && p2 != 0;
                if (it.cmd == CMD_SUB && p2 != 0) s2 = ~s2;
                if (s1 == s2) begin
                    nm = p1 + p2; nneg = s1;
                end else if (p1 >= p2) begin
                    nm = p1 - p2; nneg = s1;
                end else begin
                    nm = p2 - p1; nneg = s2;
                end
                dm = mag32(it.a_den) * mag32(it.b_den);
                dneg = it.a_den[31] ^ it.b_den[31];
            end
            CMD_MUL: begin
                nm = mag32(it.a_num) * mag32(it.b_num);
                nneg = it.a_num[31] ^ it.b_num[31];
                dm = mag32(it.a_den) * mag32(it.b_den);
                dneg = it.a_den[31] ^ it.b_den[31];
            end
            default: begin
                nm = mag32(it.a_num) * mag32(it.b_den);
                nneg = it.a_num[31] ^ it.b_den[31];
                dm = mag32(it.a_den) * mag32(it.b_num);
                dneg = it.a_den[31] ^ it.b_num[31];
            end
        endcase
        if (nm == 0) return r;
        neg = nneg ^ dneg;
        g = gcd_mag(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
            r.status = STS_OVERFLOW;
        end else begin
            r.num = neg ? (32'd0 - nm[31:0]) : nm[31:0];
            r.den = dm[30:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd1;
            4: return $urandom;
            5: return $urandom_range(0, 40) - 20;
            default: return $urandom_range(0, 2000) - 1000;
        endcase
    endfunction

    function automatic t_op_item make_op(logic [1:0] c, logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [31:0] bd);
        t_op_item it;
        it.cmd = c; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
        return it;
    endfunction

    // Fill the queue: directed corners, then random operations
    initial begin
        t_op_item it;
        pending_ops.push_back(make_op(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3));
        pending_ops.push_back(make_op(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2));
        pending_ops.push_back(make_op(CMD_MUL, -32'd6, 32'd4, 32'd2, -32'd9));
        pending_ops.push_back(make_op(CMD_DIV, 32'd3, -32'd7, -32'd9, 32'd14));
        pending_ops.push_back(make_op(CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd1));
        pending_ops.push_back(make_op(CMD_DIV, 32'd1, 32'd1, 32'd5, 32'd0));
        pending_ops.push_back(make_op(CMD_DIV, 32'd1, 32'd1, 32'd0, 32'd3));
        pending_ops.push_back(make_op(CMD_MUL, 32'd0, -32'd5, 32'd7, 32'd3));
        pending_ops.push_back(make_op(CMD_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1));
        pending_ops.push_back(make_op(CMD_DIV, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1));
        pending_ops.push_back(make_op(CMD_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1));
        pending_ops.push_back(make_op(CMD_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'd1));
        pending_ops.push_back(make_op(CMD_MUL, 32'd1, 32'h8000_0000, -32'd1, 32'd1));
        pending_ops.push_back(make_op(CMD_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1));
        pending_ops.push_back(make_op(CMD_SUB, 32'h8000_0000, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_ops.push_back(make_op(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                                      32'd1, 32'h7FFF_FFFF));
        pending_ops.push_back(make_op(CMD_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_ops.push_back(make_op(CMD_SUB, 32'd12, 32'd18, -32'd4, 32'd6));
        for (int k = 0; k < 1750; k++) begin
            it.cmd = 2'($urandom_range(0, 3));
            it.a_num = rand_field(); it.a_den = rand_field();
            it.b_num = rand_field(); it.b_den = rand_field();
            // occasional zero fields to hit the error paths
            if ($urandom_range(0, 29) == 0) it.a_den = 32'd0;
            if ($urandom_range(0, 29) == 0) it.b_den = 32'd0;
            if ($urandom_range(0, 19) == 0) it.b_num = 32'd0;
            if ($urandom_range(0, 19) == 0) it.a_num = 32'd0;
            pending_ops.push_back(it);
        end
        stimulus_done = 1'b1;
    end

    // Cycle counter; also releases reset
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == 10) i_rst_n <= 1'b1;
    end

    // Driver: present one transaction, hold it until taken, then idle a while
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_fractions.push_back(reduce_fraction(make_op(i_cmd, i_a_num, i_a_den,
                                                                     i_b_num, i_b_den)));
                i_valid <= 1'b0;
                send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            end else if (!i_valid) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                end else if (pending_ops.size() > 0) begin
                    t_op_item it;
                    it = pending_ops.pop_front();
                    i_cmd <= it.cmd;
                    i_a_num <= it.a_num; i_a_den <= it.a_den;
                    i_b_num <= it.b_num; i_b_den <= it.b_den;
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each taken result, then draw a stall for the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_fractions.size() == 0) begin
                    $error("result with nothing expected: num %h den %h status %0d",
                           o_res_num, o_res_den, o_status);
                    fail_count++;
                end else begin
                    t_fraction e;
                    e = expected_fractions.pop_front();
                    if (o_res_num !== e.num) begin
                        $error("res_num expected %h actual %h", e.num, o_res_num);
                        fail_count++;
                    end
                    if (o_res_den !== e.den) begin
                        $error("res_den expected %h actual %h", e.den, o_res_den);
                        fail_count++;
                    end
                    if (o_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, o_status);
                        fail_count++;
                    end
                end
                recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                i_stall <= (recv_wait > 0);
            end else if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                i_stall <= (recv_wait > 0);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // End of run: drain, settle, report; or give up at the cycle limit
    initial begin
        wait (stimulus_done && i_rst_n);
        while (pending_ops.size() > 0 || i_valid || expected_fractions.size() > 0) begin
            @(negedge i_clk);
            if (cycle_count > 5000000) begin
                $display("TEST FAILED");
                $finish;
            end
        end
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && expected_fractions.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
